// ===== src/egd_pkg.sv =====
// Shared types and constants for the unsigned Exp-Golomb decoder.
// No dependencies; imported by the decoder core, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package egd_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned CountBits  = 6;
  localparam int unsigned ShiftBits  = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // Open-code state carried from byte to byte
  typedef struct packed {
    logic [CountBits-1:0] prefix_zeros;
    logic                 in_suffix;
    logic [CountBits-1:0] suffix_bits_left;
    logic [ValueBits-1:0] suffix_accum;
  } dec_state_t;

  // One pending result, value formed when it moves to the output register
  typedef struct packed {
    logic [ValueBits-1:0] accum;
    logic [ShiftBits-1:0] nbits;
    status_t              status;
  } slot_t;

  // Decode of one byte: slot k belongs to bit position k (bit 7 first out)
  typedef struct packed {
    dec_state_t                 state_nxt;
    logic [ByteBits-1:0]        emit;
    slot_t [ByteBits-1:0]       slots;
  } dec_res_t;

endpackage

`default_nettype wire

// ===== src/egd_byte_dec.sv =====
// Combinational decode of one bitstream byte against the open-code state.
// Depends on egd_pkg. Eight narrow bit steps, msb first.
`timescale 1ns / 1ps
`default_nettype none

module egd_byte_dec
  import egd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = 31
) (
  input  dec_state_t           state_i,
  input  logic [ByteBits-1:0]  byte_i,
  input  logic                 end_i,
  output dec_res_t             res_o
);

  always_comb begin
    dec_state_t st;
    logic       b;
    res_o = '0;
    st    = state_i;
    for (int k = ByteBits - 1; k >= 0; k--) begin
      b = byte_i[k];
      if (!st.in_suffix) begin
        if (!b) begin
          st.prefix_zeros = st.prefix_zeros + 1'b1;
          if (st.prefix_zeros > CountBits'(MAX_PREFIX)) begin
            res_o.emit[k]         = 1'b1;
            res_o.slots[k].status = ST_TOO_LONG;
            st                    = '0;
          end
        end else if (st.prefix_zeros == '0) begin
          // single '1' bit: value zero
          res_o.emit[k]         = 1'b1;
          res_o.slots[k].status = ST_OK;
        end else begin
          st.in_suffix        = 1'b1;
          st.suffix_bits_left = st.prefix_zeros;
          st.suffix_accum     = '0;
        end
      end else begin
        st.suffix_accum     = {st.suffix_accum[ValueBits-2:0], b};
        st.suffix_bits_left = st.suffix_bits_left - 1'b1;
        if (st.suffix_bits_left == '0) begin
          res_o.emit[k]         = 1'b1;
          res_o.slots[k].status = ST_OK;
          res_o.slots[k].accum  = st.suffix_accum;
          res_o.slots[k].nbits  = st.prefix_zeros[ShiftBits-1:0];
          st                    = '0;
        end
      end
    end
    // A code open after bit 0 means bit 0 emitted nothing, so slot 0 is free
    if (end_i && (st.prefix_zeros != '0 || st.in_suffix)) begin
      res_o.emit[0]         = 1'b1;
      res_o.slots[0].status = ST_TRUNC;
      res_o.slots[0].accum  = '0;
      res_o.slots[0].nbits  = '0;
      st                    = '0;
    end
    res_o.state_nxt = st;
  end

endmodule

`default_nettype wire

// ===== src/exp_golomb_unsigned_decoder.sv =====
// Top level of the unsigned Exp-Golomb (ue) decoder: byte stream in, codes out.
// Depends on egd_pkg and egd_byte_dec.
//
// Usage:
//   Input channel in_*: one bitstream byte per item, msb consumed first;
//   in_tlast marks the final byte of a buffer.
//   Output channel out_*: one decoded code per item; out_tuser carries the
//   status (ok, truncated, prefix too long), out_tlast marks the final
//   result caused by a byte. Error results carry a zero value.
// Order: a byte is decoded in the cycle it is accepted into a bank of
//   eight result slots; its results then move one at a time from the bank
//   to the output register, which drives out_tvalid.
// Throughput: results leave the slot bank one per cycle while the output
//   is not stalled. Bytes that finish no code are taken every cycle. A new
//   byte is taken in the cycle the last slot of the previous byte moves to
//   the output register.
// Reset: rst_n low clears the open-code state, the pending flags of the
//   slot bank and the output valid.
// Stall: while out_tready is low with out_tvalid high, the output holds its item,
//   the slot bank holds, and in_tready drops once the bank has anything pending.
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_unsigned_decoder
  import egd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] code_value
  output logic [1:0]  out_tuser,   // [1:0] status
  output logic        out_tlast    // last_of_byte
);

  dec_state_t           state_r, state_nxt;
  logic [ByteBits-1:0]  pend_r, pend_nxt;
  slot_t [ByteBits-1:0] slots_r;
  dec_res_t             dec;

  logic                 out_valid_r, out_valid_nxt;
  logic [ValueBits-1:0] out_value_r, out_value_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [ByteBits-1:0]  pick;
  logic [ByteBits-1:0]  rem;
  slot_t                sel;
  logic                 move;
  logic                 accept;

  egd_byte_dec #(
    .MAX_PREFIX(MAX_PREFIX)
  ) u_dec (
    .state_i (state_r),
    .byte_i  (in_tdata),
    .end_i   (in_tlast),
    .res_o   (dec)
  );

  // Highest pending bit position goes out first
  always_comb begin
    pick = '0;
    sel  = '0;
    for (int k = 0; k < ByteBits; k++) begin
      if (pend_r[k]) begin
        pick    = '0;
        pick[k] = 1'b1;
        sel     = slots_r[k];
      end
    end
  end

  assign rem       = pend_r & ~pick;
  assign move      = (pend_r != '0) && (!out_valid_r || out_tready);
  assign in_tready = (pend_r == '0) || (move && rem == '0);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    if (accept) begin
      state_nxt = dec.state_nxt;
      pend_nxt  = dec.emit;
    end else if (move) begin
      pend_nxt = rem;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (move) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = sel.status;
      out_last_nxt   = (rem == '0);
      // suffix < 2^n, so the sum stays within 32 bits
      out_value_nxt  = (sel.status == ST_OK)
                     ? ((ValueBits'(1) << sel.nbits) - ValueBits'(1) + sel.accum)
                     : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots_r <= dec.slots;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== src/egd_checker.sv =====
// Port-level checker for the unsigned Exp-Golomb decoder, bound to the top level.
// Depends on egd_pkg and exp_golomb_unsigned_decoder.
`timescale 1ns / 1ps
`default_nettype none

module egd_checker
  import egd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_TRUNC || out_tuser == ST_TOO_LONG) |-> out_tdata == '0)
    else $error("error result with nonzero value");

  // truncation is always the final result of its byte
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_TRUNC |-> out_tlast)
    else $error("truncated result not last of byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_TRUNC || out_tuser == ST_TOO_LONG))
    else $error("undefined status code");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 32'hFFFF_FFFF)
    else $error("code value out of range");

endmodule

bind exp_golomb_unsigned_decoder egd_checker u_egd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
